// File: hdl/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw assertion failed");
`else
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, command and character codes, CRTC register indexes and the
// descriptor that carries one command's writes to the output sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

   // Default geometry of the console.
   localparam int DEF_ROW_CELLS    = 80;
   localparam int DEF_WINDOW_CELLS = 2000;

   // Field widths.
   localparam int FUNC_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int OFFSET_W = 15;
   localparam int CELL_W   = 16;
   localparam int ORIGIN_W = 14;
   localparam int LIMIT_W  = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // Command codes.
   localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UP     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DOWN   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

   // Special character codes.
   localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;

   // CRTC register indexes.
   localparam logic [7:0] CRTC_CUR_HI   = 8'h0E;
   localparam logic [7:0] CRTC_CUR_LO   = 8'h0F;
   localparam logic [7:0] CRTC_START_HI = 8'h0C;
   localparam logic [7:0] CRTC_START_LO = 8'h0D;

   // Output kinds and CRTC port selects.
   localparam logic KIND_MEM  = 1'b0;
   localparam logic KIND_PORT = 1'b1;
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [ORIGIN_W-1:0] RST_ORIGIN = 14'd0;
   localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 15'd16384;
   localparam logic [7:0]          RST_ATTR   = 8'd7;

   // Writes caused by one command: an optional cell write (character and
   // attribute), then zero, one or two CRTC flushes of cursor and start.
   typedef struct packed {
      logic                has_mem;
      logic [13:0]         mem_cell;
      logic [CHAR_W-1:0]   mem_char;
      logic [7:0]          mem_attr;
      logic [1:0]          flush_cnt;
      logic [CELL_W-1:0]   cursor;
      logic [CELL_W-1:0]   window;
   } plan_type;

endpackage

// File: hdl/tcw_if.sv
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready channels for commands and for memory and CRTC write words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::FUNC_W-1:0]    func;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;

   modport source (output valid, output func, output char_code, input ready);
   modport sink   (input valid, input func, input char_code, output ready);
endinterface

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [tcw_pkg::OFFSET_W-1:0]  mem_offset;
   logic                          port_sel;
   logic [7:0]                    data;
   logic                          last;

   modport source (output valid, output kind, output mem_offset, output port_sel,
                   output data, output last, input ready);
   modport sink   (input valid, input kind, input mem_offset, input port_sel,
                   input data, input last, output ready);
endinterface

// File: hdl/tcw_update.sv
// ----------------------------------------------------------------------------
// Text console writer state update
// Applies one command to the cursor and window start and describes the
// memory and CRTC writes that the command causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_update #(
   parameter int ROW_CELLS    = tcw_pkg::DEF_ROW_CELLS,
   parameter int WINDOW_CELLS = tcw_pkg::DEF_WINDOW_CELLS
) (
   input  logic [tcw_pkg::FUNC_W-1:0]   func,
   input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
   input  logic [tcw_pkg::CELL_W-1:0]   cursor,
   input  logic [tcw_pkg::CELL_W-1:0]   window,
   input  logic [tcw_pkg::ORIGIN_W-1:0] origin,
   input  logic [tcw_pkg::LIMIT_W-1:0]  limit,
   input  logic [7:0]                   attr,
   input  logic                         is_current,
   output logic [tcw_pkg::CELL_W-1:0]   cursor_next,
   output logic [tcw_pkg::CELL_W-1:0]   window_next,
   output tcw_pkg::plan_type            plan
);

   // Column by reciprocal multiplication: exact for every 16-bit operand.
   localparam int SHIFT = 16 + $clog2(ROW_CELLS);
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(ROW_CELLS) - 64'd1) / 64'(ROW_CELLS);
   localparam logic [16:0] RECIP17 = 17'(RECIP);
   localparam logic [15:0] ROW16   = 16'(ROW_CELLS);
   localparam logic [23:0] ROW24   = 24'(ROW_CELLS);
   localparam logic [17:0] ROW18   = 18'(ROW_CELLS);
   localparam logic [17:0] WIN18   = 18'(WINDOW_CELLS);

   logic [17:0] end18;
   logic [17:0] cursor18;
   logic [17:0] window18;
   logic [15:0] rel;
   logic [32:0] prod;
   logic [15:0] quot;
   logic [23:0] quot_row;
   logic [15:0] col;
   logic        nl_ok;
   logic        bs_ok;
   logic        ch_ok;
   logic        dn_ok;
   logic        up_ok;
   logic [15:0] cursor_put;
   logic        has_mem;
   logic [15:0] mem_cell;
   logic [7:0]  mem_char;
   logic        passed;
   logic [15:0] window_dn;
   logic [15:0] window_up;

   // Bounds of the console region, compared without wrap.
   assign end18    = 18'(origin) + 18'(limit);
   assign cursor18 = 18'(cursor);
   assign window18 = 18'(window);

   // Column of the cursor inside its row.
   assign rel      = cursor - 16'(origin);
   assign prod     = 33'(rel) * 33'(RECIP17);
   assign quot     = 16'(prod >> SHIFT);
   assign quot_row = 24'(quot) * ROW24;
   assign col      = rel - quot_row[15:0];

   assign nl_ok = (cursor18 + ROW18) < end18;
   assign bs_ok = cursor > 16'(origin);
   assign ch_ok = (cursor18 + 18'd1) < end18;
   assign dn_ok = (window18 + WIN18) < end18;
   assign up_ok = window > 16'(origin);

   assign window_dn = window + ROW16;
   assign window_up = window - ROW16;

   // Cursor step and cell write of a put command.
   always_comb begin
      cursor_put = cursor;
      has_mem    = 1'b0;
      mem_cell   = cursor;
      mem_char   = char_code;
      if (char_code == tcw_pkg::CHAR_NEWLINE) begin
         if (nl_ok) begin
            cursor_put = cursor + ROW16 - col;
         end
      end else if (char_code == tcw_pkg::CHAR_BACKSPACE) begin
         if (bs_ok) begin
            cursor_put = cursor - 16'd1;
            has_mem    = 1'b1;
            mem_cell   = cursor - 16'd1;
            mem_char   = tcw_pkg::CHAR_BLANK;
         end
      end else if (char_code != tcw_pkg::CHAR_NUL) begin
         if (ch_ok) begin
            cursor_put = cursor + 16'd1;
            has_mem    = 1'b1;
         end
      end
   end

   // Window passed after the put.
   assign passed = 18'(cursor_put) >= (window18 + WIN18);

   // Next state and the list of writes.
   always_comb begin
      cursor_next    = cursor;
      window_next    = window;
      plan.has_mem   = 1'b0;
      plan.mem_cell  = mem_cell[13:0];
      plan.mem_char  = mem_char;
      plan.mem_attr  = attr;
      plan.flush_cnt = 2'd0;
      case (func)
         tcw_pkg::FUNC_PUT: begin
            if (char_code != tcw_pkg::CHAR_NUL) begin
               cursor_next  = cursor_put;
               plan.has_mem = has_mem;
               if (passed && dn_ok) begin
                  window_next = window_dn;
               end
               if (is_current) begin
                  plan.flush_cnt = passed ? 2'd2 : 2'd1;
               end
            end
         end
         tcw_pkg::FUNC_UP: begin
            if (up_ok) begin
               window_next = window_up;
            end
            plan.flush_cnt = {1'b0, is_current};
         end
         tcw_pkg::FUNC_DOWN: begin
            if (dn_ok) begin
               window_next = window_dn;
            end
            plan.flush_cnt = {1'b0, is_current};
         end
         default: begin
            plan.flush_cnt = 2'd1;
         end
      endcase
      plan.cursor = cursor_next;
      plan.window = window_next;
   end

endmodule

// File: hdl/tcw_emitter.sv
// ----------------------------------------------------------------------------
// Text console writer output sequencer
// Holds one command's write list, sending one word per cycle while ready is
// high: the cell writes first, then each CRTC flush as four index/data pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  tcw_pkg::plan_type plan,
   output logic              free,
   tcw_rsp_if.source         rsp_ch
);

   tcw_pkg::plan_type plan_ff;
   tcw_pkg::plan_type plan_in;
   logic              valid_ff;
   logic              valid_in;
   logic [4:0]        step_ff;
   logic [4:0]        step_in;
   logic [4:0]        total;
   logic              mem_phase;
   logic [4:0]        flush_step;
   logic [2:0]        word;
   logic              is_last;
   logic              fire;

   // Number of words in the held list.
   assign total = {plan_ff.flush_cnt, 3'b000} + {3'b000, plan_ff.has_mem, 1'b0};

   assign mem_phase  = plan_ff.has_mem && (step_ff[4:1] == 4'd0);
   assign flush_step = plan_ff.has_mem ? (step_ff - 5'd2) : step_ff;
   assign word       = flush_step[2:0];
   assign is_last    = step_ff == (total - 5'd1);

   assign fire = valid_ff && rsp_ch.ready;
   assign free = !valid_ff || (fire && is_last);

   // Word formatting.
   always_comb begin
      rsp_ch.valid      = valid_ff;
      rsp_ch.last       = is_last;
      rsp_ch.kind       = tcw_pkg::KIND_PORT;
      rsp_ch.mem_offset = '0;
      rsp_ch.port_sel   = word[0];
      rsp_ch.data       = '0;
      if (mem_phase) begin
         rsp_ch.kind       = tcw_pkg::KIND_MEM;
         rsp_ch.mem_offset = {plan_ff.mem_cell, step_ff[0]};
         rsp_ch.port_sel   = tcw_pkg::PORT_INDEX;
         rsp_ch.data       = step_ff[0] ? plan_ff.mem_attr : plan_ff.mem_char;
      end else begin
         case (word)
            3'd0: rsp_ch.data = tcw_pkg::CRTC_CUR_HI;
            3'd1: rsp_ch.data = plan_ff.cursor[15:8];
            3'd2: rsp_ch.data = tcw_pkg::CRTC_CUR_LO;
            3'd3: rsp_ch.data = plan_ff.cursor[7:0];
            3'd4: rsp_ch.data = tcw_pkg::CRTC_START_HI;
            3'd5: rsp_ch.data = plan_ff.window[15:8];
            3'd6: rsp_ch.data = tcw_pkg::CRTC_START_LO;
            default: rsp_ch.data = plan_ff.window[7:0];
         endcase
      end
   end

   // List register and word counter.
   always_comb begin
      plan_in  = plan_ff;
      valid_in = valid_ff;
      step_in  = step_ff;
      if (load) begin
         plan_in  = plan;
         valid_in = 1'b1;
         step_in  = 5'd0;
      end else if (fire && is_last) begin
         valid_in = 1'b0;
      end else if (fire) begin
         step_in = step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 5'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
   end

endmodule

// File: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console engine: cursor and window tracking with video memory
// and CRTC write generation.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on req_ch (func, char_code) with a valid/ready handshake.
// Each command produces zero to eighteen words on rsp_ch: video memory byte
// writes (character then attribute) followed by CRTC index/data pairs for
// cursor and start address; last marks the final word of a command.
// The csr_ port writes origin, memory limit, attribute and current flag; it
// must be written only while the block is idle, which the block does not enforce.
// A command accepted into the input register is applied when the output
// sequencer is free, which loads the command's words into the sequencer.
// The output sequencer sends one word per cycle while the receiver is ready;
// a command with no words never occupies it. One command waits in the input
// register while the previous command's words drain.
// When the receiver stalls, the current word holds and req_ch.ready drops
// once the input register is also full.
// Reset clears cursor and window start to zero, loads the register defaults
// and empties both stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module text_console_writer #(
   parameter int ROW_CELLS    = tcw_pkg::DEF_ROW_CELLS,
   parameter int WINDOW_CELLS = tcw_pkg::DEF_WINDOW_CELLS
) (
   input  logic                              clock,
   input  logic                              reset,
   tcw_req_if.sink                           req_ch,
   tcw_rsp_if.source                         rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [tcw_pkg::ORIGIN_W-1:0] origin_ff;
   logic [tcw_pkg::LIMIT_W-1:0]  limit_ff;
   logic [7:0]                   attr_ff;
   logic                         current_ff;

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [tcw_pkg::FUNC_W-1:0]   s1_func_ff;
   logic [tcw_pkg::CHAR_W-1:0]   s1_char_ff;

   logic [tcw_pkg::CELL_W-1:0]   cursor_ff;
   logic [tcw_pkg::CELL_W-1:0]   cursor_in;
   logic [tcw_pkg::CELL_W-1:0]   window_ff;
   logic [tcw_pkg::CELL_W-1:0]   window_in;
   logic [tcw_pkg::CELL_W-1:0]   cursor_next;
   logic [tcw_pkg::CELL_W-1:0]   window_next;

   tcw_pkg::plan_type            plan;
   logic                         emit_free;
   logic                         s1_adv;
   logic                         plan_load;
   logic                         req_fire;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff  <= tcw_pkg::RST_ORIGIN;
         limit_ff   <= tcw_pkg::RST_LIMIT;
         attr_ff    <= tcw_pkg::RST_ATTR;
         current_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            tcw_pkg::CSR_ORIGIN:  origin_ff  <= csr_wdata[tcw_pkg::ORIGIN_W-1:0];
            tcw_pkg::CSR_LIMIT:   limit_ff   <= csr_wdata[tcw_pkg::LIMIT_W-1:0];
            tcw_pkg::CSR_ATTR:    attr_ff    <= csr_wdata[7:0];
            tcw_pkg::CSR_CURRENT: current_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Input register handshake.
   assign s1_adv        = s1_valid_ff && emit_free;
   assign req_ch.ready  = !s1_valid_ff || emit_free;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign plan_load     = s1_adv && (plan.has_mem || (plan.flush_cnt != 2'd0));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff <= req_ch.func;
         s1_char_ff <= req_ch.char_code;
      end
   end

   // Console state update.
   tcw_update #(
      .ROW_CELLS    (ROW_CELLS),
      .WINDOW_CELLS (WINDOW_CELLS)
   ) u_update (
      .func        (s1_func_ff),
      .char_code   (s1_char_ff),
      .cursor      (cursor_ff),
      .window      (window_ff),
      .origin      (origin_ff),
      .limit       (limit_ff),
      .attr        (attr_ff),
      .is_current  (current_ff),
      .cursor_next (cursor_next),
      .window_next (window_next),
      .plan        (plan)
   );

   assign cursor_in = s1_adv ? cursor_next : cursor_ff;
   assign window_in = s1_adv ? window_next : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         window_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
         window_ff <= window_in;
      end
   end

   // Output word sequencer.
   tcw_emitter u_emitter (
      .clock  (clock),
      .reset  (reset),
      .load   (plan_load),
      .plan   (plan),
      .free   (emit_free),
      .rsp_ch (rsp_ch)
   );

   // A stalled input side means both stages hold a command.
   `TCW_ASSERT_IMPL(a_stall_full, clock, reset, !req_ch.ready,
      s1_valid_ff && rsp_ch.valid)
   // The cursor moves only when a command is applied.
   `TCW_ASSERT_NEXT(a_cursor_hold, clock, reset, !s1_adv, $stable(cursor_ff))
   // A forced flush always produces words.
   `TCW_ASSERT_NEXT(a_flush_words, clock, reset,
      s1_adv && (s1_func_ff == tcw_pkg::FUNC_FLUSH), rsp_ch.valid)
   // A zero byte produces nothing.
   `TCW_ASSERT_NEXT(a_nul_silent, clock, reset,
      s1_adv && (s1_func_ff == tcw_pkg::FUNC_PUT) && (s1_char_ff == tcw_pkg::CHAR_NUL),
      !rsp_ch.valid)

endmodule

// File: tb/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, scroll and flush commands into the console engine while both
// channels idle and stall at random. Each accepted command is run through a
// cycle-free model of cursor and window tracking. The memory and CRTC write
// words that come back are compared field by field, in order, with the
// model's words. The run covers several console settings, the extremes
// among them.
// ----------------------------------------------------------------------------

module text_console_writer_tb;

   localparam int ROW_SIZE    = tcw_pkg::DEF_ROW_CELLS;
   localparam int WINDOW_SIZE = tcw_pkg::DEF_WINDOW_CELLS;
   localparam int MAX_WORDS   = 18;

   // One memory or CRTC write word as seen on the result channel.
   typedef struct {
      logic                         kind;
      logic [tcw_pkg::OFFSET_W-1:0] offset;
      logic                         sel;
      logic [7:0]                   data;
      logic                         last;
   } console_write_type;

   // Console model: cursor, window and settings, plus the words still owed.
   class console_scoreboard;
      logic [tcw_pkg::ORIGIN_W-1:0] origin;
      logic [tcw_pkg::LIMIT_W-1:0]  limit;
      logic [7:0]                   attr;
      logic                         current;
      logic [tcw_pkg::CELL_W-1:0]   cursor;
      logic [tcw_pkg::CELL_W-1:0]   window;
      console_write_type            owed_words[$];
      console_write_type            batch[$];
      int                           n_errors;
      int                           n_commands;
      int                           n_words;
      int                           n_full;

      function new();
         origin     = tcw_pkg::RST_ORIGIN;
         limit      = tcw_pkg::RST_LIMIT;
         attr       = tcw_pkg::RST_ATTR;
         current    = 1'b1;
         cursor     = '0;
         window     = '0;
         n_errors   = 0;
         n_commands = 0;
         n_words    = 0;
         n_full     = 0;
      endfunction

      function void set_register(logic [tcw_pkg::CSR_IDX_W-1:0] idx,
                                 logic [tcw_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            tcw_pkg::CSR_ORIGIN:  origin  = val[tcw_pkg::ORIGIN_W-1:0];
            tcw_pkg::CSR_LIMIT:   limit   = val[tcw_pkg::LIMIT_W-1:0];
            tcw_pkg::CSR_ATTR:    attr    = val[7:0];
            tcw_pkg::CSR_CURRENT: current = val[0];
            default: ;
         endcase
      endfunction

      function void add_write(logic kind, logic [tcw_pkg::OFFSET_W-1:0] offset,
                              logic sel, logic [7:0] data);
         console_write_type w;
         w.kind   = kind;
         w.offset = offset;
         w.sel    = sel;
         w.data   = data;
         w.last   = 1'b0;
         batch.push_back(w);
      endfunction

      // Character then attribute at the cursor cell; the offset wraps to 15 bits.
      // The port select reads as zero on memory writes.
      function void add_cell(logic [7:0] ch);
         logic [tcw_pkg::OFFSET_W-1:0] off;
         off = {cursor[tcw_pkg::ORIGIN_W-1:0], 1'b0};
         add_write(tcw_pkg::KIND_MEM, off, tcw_pkg::PORT_INDEX, ch);
         add_write(tcw_pkg::KIND_MEM, off | 15'd1, tcw_pkg::PORT_INDEX, attr);
      endfunction

      // Cursor and start address, each as an index word and a data word.
      function void add_flush(bit forced);
         if (forced || current) begin
            add_write(tcw_pkg::KIND_PORT, '0, tcw_pkg::PORT_INDEX, tcw_pkg::CRTC_CUR_HI);
            add_write(tcw_pkg::KIND_PORT, '0, tcw_pkg::PORT_DATA, cursor[15:8]);
            add_write(tcw_pkg::KIND_PORT, '0, tcw_pkg::PORT_INDEX, tcw_pkg::CRTC_CUR_LO);
            add_write(tcw_pkg::KIND_PORT, '0, tcw_pkg::PORT_DATA, cursor[7:0]);
            add_write(tcw_pkg::KIND_PORT, '0, tcw_pkg::PORT_INDEX, tcw_pkg::CRTC_START_HI);
            add_write(tcw_pkg::KIND_PORT, '0, tcw_pkg::PORT_DATA, window[15:8]);
            add_write(tcw_pkg::KIND_PORT, '0, tcw_pkg::PORT_INDEX, tcw_pkg::CRTC_START_LO);
            add_write(tcw_pkg::KIND_PORT, '0, tcw_pkg::PORT_DATA, window[7:0]);
         end
      endfunction

      // Bounds are compared as plain integers; only the stored window wraps.
      function void scroll_window(bit down);
         int top;
         top = int'(origin) + int'(limit);
         if (down) begin
            if (int'(window) + WINDOW_SIZE < top) window = window + 16'(ROW_SIZE);
         end else if (int'(window) > int'(origin)) begin
            window = window - 16'(ROW_SIZE);
         end
         add_flush(1'b0);
      endfunction

      function void put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
         int                         top;
         logic [tcw_pkg::CELL_W-1:0] rel;
         top = int'(origin) + int'(limit);
         if (ch == tcw_pkg::CHAR_NUL) return;
         if (ch == tcw_pkg::CHAR_NEWLINE) begin
            // The column is taken relative to the origin, modulo 2^16.
            if (int'(cursor) + ROW_SIZE < top) begin
               rel    = cursor - 16'(origin);
               cursor = cursor + 16'(ROW_SIZE) - (rel % 16'(ROW_SIZE));
            end
         end else if (ch == tcw_pkg::CHAR_BACKSPACE) begin
            if (cursor > 16'(origin)) begin
               cursor = cursor - 16'd1;
               add_cell(tcw_pkg::CHAR_BLANK);
            end
         end else if (int'(cursor) + 1 < top) begin
            add_cell(ch);
            cursor = cursor + 16'd1;
         end
         // At most one scroll per command, however far the cursor has run.
         if (int'(cursor) >= int'(window) + WINDOW_SIZE) scroll_window(1'b1);
         add_flush(1'b0);
      endfunction

      function void note_command(logic [tcw_pkg::FUNC_W-1:0] func,
                                 logic [tcw_pkg::CHAR_W-1:0] ch);
         console_write_type w;
         batch.delete();
         case (func)
            tcw_pkg::FUNC_PUT:  put_char(ch);
            tcw_pkg::FUNC_UP:   scroll_window(1'b0);
            tcw_pkg::FUNC_DOWN: scroll_window(1'b1);
            default:            add_flush(1'b1);
         endcase
         if (batch.size() > 0) begin
            w      = batch.pop_back();
            w.last = 1'b1;
            batch.push_back(w);
         end
         if (batch.size() == MAX_WORDS) n_full++;
         foreach (batch[i]) owed_words.push_back(batch[i]);
         n_commands++;
      endfunction

      function void report_field(string field, logic [tcw_pkg::OFFSET_W-1:0] want,
                                 logic [tcw_pkg::OFFSET_W-1:0] got);
         n_errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      endfunction

      function void check_word(console_write_type got);
         console_write_type want;
         n_words++;
         if (owed_words.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected word, kind %0h offset %0h sel %0h data %0h last %0h",
                     $time, got.kind, got.offset, got.sel, got.data, got.last);
            return;
         end
         want = owed_words.pop_front();
         if (got.kind !== want.kind)
            report_field("kind", 15'(want.kind), 15'(got.kind));
         if (got.offset !== want.offset)
            report_field("mem_offset", want.offset, got.offset);
         if (got.sel !== want.sel)
            report_field("port_sel", 15'(want.sel), 15'(got.sel));
         if (got.data !== want.data)
            report_field("data", 15'(want.data), 15'(got.data));
         if (got.last !== want.last)
            report_field("last", 15'(want.last), 15'(got.last));
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   console_scoreboard sb;
   console_write_type seen;
   bit                idle_on;
   int                n_settings;

   text_console_writer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Note accepted commands and check accepted words at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_command(req_ch.func, req_ch.char_code);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.kind   = rsp_ch.kind;
            seen.offset = rsp_ch.mem_offset;
            seen.sel    = rsp_ch.port_sel;
            seen.data   = rsp_ch.data;
            seen.last   = rsp_ch.last;
            sb.check_word(seen);
         end
      end
   end

   // Receiver: runs of ready broken by random stalls.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && gap_len() > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap_len() + 1) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Offer one command word and hold it until it is taken. Valid stays high
   // into the next command unless a gap is wanted.
   task automatic send_cmd(input logic [tcw_pkg::FUNC_W-1:0] func,
                           input logic [tcw_pkg::CHAR_W-1:0] ch);
      int gap;
      gap = idle_on ? gap_len() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= func;
      req_ch.char_code <= ch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Stop sending and wait until every owed word has come back. The extra
   // cycles cover a command with no words still inside the block.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [tcw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tcw_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_register(idx, val);
      @(posedge clock);
   endtask

   // Write all four registers back to back; the block must be idle.
   task automatic set_config(input int org, input int lim, input int attr, input int cur);
      write_csr(tcw_pkg::CSR_ORIGIN, 15'(org));
      write_csr(tcw_pkg::CSR_LIMIT, 15'(lim));
      write_csr(tcw_pkg::CSR_ATTR, 15'(attr));
      write_csr(tcw_pkg::CSR_CURRENT, 15'(cur));
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   task automatic send_random_cmd();
      int                         pick;
      logic [tcw_pkg::CHAR_W-1:0] ch;
      pick = $urandom_range(0, 99);
      ch   = 8'($urandom_range(0, 255));
      if (pick < 30) send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NEWLINE);
      else if (pick < 40) send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BACKSPACE);
      else if (pick < 44) send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NUL);
      else if (pick < 78) send_cmd(tcw_pkg::FUNC_PUT, ch);
      else if (pick < 85) send_cmd(tcw_pkg::FUNC_UP, ch);
      else if (pick < 93) send_cmd(tcw_pkg::FUNC_DOWN, ch);
      else send_cmd(tcw_pkg::FUNC_FLUSH, ch);
   endtask

   // Directed part: every command, the special bytes and the bounds.
   task automatic run_directed();
      // Reset settings: nothing to step back over or scroll up past.
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NUL);
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BACKSPACE);
      send_cmd(tcw_pkg::FUNC_UP, 8'h00);
      send_cmd(tcw_pkg::FUNC_DOWN, 8'hFF);
      send_cmd(tcw_pkg::FUNC_UP, 8'h55);
      send_cmd(tcw_pkg::FUNC_FLUSH, 8'hFF);
      send_cmd(tcw_pkg::FUNC_PUT, 8'hFF);
      send_cmd(tcw_pkg::FUNC_PUT, 8'h01);
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BLANK);
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BACKSPACE);

      // Walk the cursor down to the last row of the window, then cross it
      // with a newline; the window scrolls down once.
      repeat (25) send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NEWLINE);

      // Step back inside, pull the window up, and cross again with a
      // character: cell write, scroll flush and put flush all at once.
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BACKSPACE);
      send_cmd(tcw_pkg::FUNC_UP, 8'hAA);
      send_cmd(tcw_pkg::FUNC_PUT, 8'h41);

      // Console not current: only the forced flush reaches the CRTC.
      wait_drained();
      set_config(16383, 16384, 255, 0);
      send_cmd(tcw_pkg::FUNC_FLUSH, 8'h00);
      send_cmd(tcw_pkg::FUNC_DOWN, 8'h00);
      send_cmd(tcw_pkg::FUNC_PUT, 8'h7F);
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NUL);

      // Empty console: no room for a character, a newline or a scroll down.
      wait_drained();
      set_config(0, 0, 0, 1);
      send_cmd(tcw_pkg::FUNC_PUT, 8'h80);
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NEWLINE);
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BACKSPACE);
      send_cmd(tcw_pkg::FUNC_DOWN, 8'h00);
      send_cmd(tcw_pkg::FUNC_UP, 8'h00);

      // Limit two cells past the cursor: one more character fits, then none.
      wait_drained();
      set_config(0, int'(sb.cursor) + 2, 'h5A, 1);
      send_cmd(tcw_pkg::FUNC_PUT, 8'h42);
      send_cmd(tcw_pkg::FUNC_PUT, 8'h43);
      send_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NEWLINE);
      wait_drained();
   endtask

   // One random phase under a setting picked from the current state.
   task automatic run_phase(input int phase_no, input int count, input int hold_at);
      int org;
      int lim;
      int cur;
      case (phase_no % 4)
         0: begin
            org = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, int'(sb.cursor)));
            lim = 16384;
         end
         1: begin
            // Tight limit just beyond the cursor, to reach the end of memory.
            org = int'(sb.cursor) - int'($urandom_range(0, 400));
            if (org < 0) org = 0;
            lim = int'(sb.cursor) - org + int'($urandom_range(0, 200));
         end
         2: begin
            org = $urandom_range(0, 16383);
            lim = $urandom_range(0, 16384);
         end
         default: begin
            org = 16383;
            lim = $urandom_range(0, 1) ? 16384 : 0;
         end
      endcase
      if (org > 16383) org = 16383;
      if (lim > 16384) lim = 16384;
      if (phase_no % 4 == 2) cur = $urandom_range(0, 1);
      else cur = ($urandom_range(0, 3) != 0) ? 1 : 0;
      set_config(org, lim, $urandom_range(0, 255), cur);
      idle_on = (phase_no != 3);
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) wait_drained();
         send_random_cmd();
      end
      wait_drained();
   endtask

   // Stimulus and end of run.
   initial begin
      sb                 = new();
      idle_on            = 1'b1;
      n_settings         = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= tcw_pkg::FUNC_PUT;
      req_ch.char_code <= tcw_pkg::CHAR_NUL;
      csr_wr_en        <= 1'b0;
      csr_index        <= tcw_pkg::CSR_ORIGIN;
      csr_wdata        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      for (int p = 0; p < 8; p++) run_phase(p, 36, (p == 5) ? 18 : -1);

      wait_drained();
      repeat (12) @(posedge clock);
      if (sb.owed_words.size() != 0)
         $display("%0d expected words never arrived", sb.owed_words.size());
      $display("Run covered %0d commands and %0d write words under %0d console settings,",
               sb.n_commands, sb.n_words, n_settings);
      $display("including %0d commands that produced the full eighteen words.", sb.n_full);
      if (sb.n_errors == 0 && sb.owed_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Run limit, well beyond the slowest correct run.
   initial begin
      #20000000;
      $display("Timeout with %0d words still expected", sb.owed_words.size());
      $display("FAIL");
      $finish;
   end

endmodule
